/* src/assert_macros.svh */
// assertion macros used by the rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STRAMP_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define STRAMP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define STRAMP_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define STRAMP_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* src/stramp_pkg.sv */
// types and constants of the trapezoid ramp generator
package stramp_pkg;

    localparam int unsigned SPEED_W  = 24;
    localparam int unsigned DIST_W   = 24;
    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned TFREQ_W  = 27;
    localparam int unsigned FRAC_W   = 8;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_MOVE = 2'd1,
        KIND_RUN  = 2'd2,
        KIND_STOP = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_TARGET = 2'd0,
        CFG_ACCEL  = 2'd1,
        CFG_START  = 2'd2,
        CFG_TFREQ  = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] MODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_COUNTED = 2'd1;
    localparam logic [1:0] MODE_RUN     = 2'd2;

    localparam logic [1:0] RAMP_CRUISE = 2'd0;
    localparam logic [1:0] RAMP_ACCEL  = 2'd1;
    localparam logic [1:0] RAMP_DECEL  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TMUL,
        ST_TSQ,
        ST_SQRT,
        ST_TUPD,
        ST_FINISH,
        ST_DIV,
        ST_PER,
        ST_MMUL,
        ST_MCMP,
        ST_MSQ,
        ST_MSET,
        ST_EMIT
    } t_state;

endpackage

/* src/stepper_trapezoid_ramp.sv */
// trapezoid ramp generator: per-step timer periods for a stepper motor
//
// Commands arrive on the slave stream: tuser holds the kind (tick, counted
// move, run, stop), tdata the step count of a counted move. Every command
// gives exactly one result on the master stream: period, mode and ramp.
// Configuration is a plain write port (target speed, acceleration, start
// speed, timer clock); the user must write it only while the block is idle;
// the block does not enforce this. One command is worked on at a time;
// tready is low while it is busy. A tick that changes speed runs one 24x24
// multiply, a 32-step shared square root unit and a 48-step shared
// restoring divider one after the other. A counted move runs the multiply
// and the divide, and the square root too when the move is too short to
// reach the target and the peak needs one. A tick from zero speed only
// divides; a tick that brings the motor to rest multiplies, with or without
// the square root. Other commands and cruising ticks use none of the units.
// The result sits in an output register; the next command is taken while
// it waits, and a finished result waits for the register to empty when the
// receiver stalls.
// Reset (synchronous, active low) gives standby, zero speed, the default
// start speed and timer clock, and an unconfigured block.
`include "assert_macros.svh"

module stepper_trapezoid_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [26:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // distance
    input  logic [1:0]  i_s_tuser,   // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // period, mode, ramp, zero fill
);

    stramp_pkg::t_state r_state, n_state;

    logic [23:0] r_target, r_accel, r_start;
    logic [26:0] r_tfreq;
    logic [1:0]  r_mode, n_mode, r_ramp, n_ramp;
    logic [23:0] r_speed, n_speed, r_wt, n_wt, r_steps, n_steps, r_travel, n_travel;
    logic [31:0] r_rdist, n_rdist, r_period, n_period, r_res, n_res;
    logic [47:0] r_prod, n_prod;
    logic [47:0] r_dnum, n_dnum;
    logic [40:0] r_drem, n_drem;
    logic [39:0] r_dden, n_dden;
    logic [5:0]  r_dcnt, n_dcnt;
    logic [63:0] r_sx, n_sx;
    logic [31:0] r_sroot, n_sroot;
    logic [34:0] r_srem, n_srem;
    logic [4:0]  r_scnt, n_scnt;
    logic        r_is_move, n_is_move;
    logic        r_out_valid;
    logic [31:0] r_out_period;
    logic [1:0]  r_out_mode, r_out_ramp;
    logic        emit_load;

    logic        cfg_ok;
    logic [23:0] mul_a, mul_b;
    logic [47:0] mul_p;
    logic [40:0] div_sh;
    logic        div_ge;
    logic [34:0] sq_sh, sq_trial;
    logic        sq_ge;
    logic [40:0] k_acc;
    logic [48:0] v2_plus;
    logic [22:0] half;
    logic        q_long;
    logic [1:0]  ramp_go;

    assign cfg_ok   = (r_target != '0) && (r_accel != '0);
    assign mul_p    = {24'd0, mul_a} * {24'd0, mul_b};
    assign div_sh   = {r_drem[39:0], r_dnum[47]};
    assign div_ge   = div_sh >= {1'b0, r_dden};
    assign sq_sh    = {r_srem[32:0], r_sx[63:62]};
    assign sq_trial = {1'b0, r_sroot, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign k_acc    = {r_accel, 17'd0};
    assign v2_plus  = {1'b0, r_prod} + {8'd0, k_acc};
    assign half     = r_travel[23:1];
    assign q_long   = (r_dnum > {24'd0, r_travel})
                   || ((r_dnum == {24'd0, r_travel}) && (r_drem != '0));
    assign ramp_go  = (r_ramp == stramp_pkg::RAMP_CRUISE) ? stramp_pkg::RAMP_DECEL : r_ramp;

    always_comb begin
        unique case (r_state)
            stramp_pkg::ST_TMUL: begin
                mul_a = r_speed;
                mul_b = r_speed;
            end
            stramp_pkg::ST_MMUL: begin
                mul_a = r_target;
                mul_b = r_target;
            end
            default: begin
                mul_a = {half, 1'b0};
                mul_b = r_accel;
            end
        endcase
    end

    assign o_s_tready = (r_state == stramp_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_ramp, r_out_mode, r_out_period};
    assign emit_load  = (r_state == stramp_pkg::ST_EMIT) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_ramp    = r_ramp;
        n_speed   = r_speed;
        n_wt      = r_wt;
        n_steps   = r_steps;
        n_travel  = r_travel;
        n_rdist   = r_rdist;
        n_period  = r_period;
        n_res     = r_res;
        n_prod    = r_prod;
        n_dnum    = r_dnum;
        n_drem    = r_drem;
        n_dden    = r_dden;
        n_dcnt    = r_dcnt;
        n_sx      = r_sx;
        n_sroot   = r_sroot;
        n_srem    = r_srem;
        n_scnt    = r_scnt;
        n_is_move = r_is_move;
        unique case (r_state)
            stramp_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = stramp_pkg::ST_EMIT;
                    n_res   = r_period;
                    unique case (stramp_pkg::t_kind'(i_s_tuser))
                        stramp_pkg::KIND_TICK: begin
                            if (!cfg_ok || r_mode == stramp_pkg::MODE_STANDBY) begin
                                n_res = '0;
                            end else if (r_ramp == stramp_pkg::RAMP_CRUISE
                                         && r_mode != stramp_pkg::MODE_COUNTED) begin
                                n_res = r_period;
                            end else if (r_ramp == stramp_pkg::RAMP_CRUISE
                                         && {8'd0, r_steps} > r_rdist) begin
                                n_steps = r_steps - 24'd1;
                            end else begin
                                if (r_ramp == stramp_pkg::RAMP_CRUISE) begin
                                    n_wt = r_start;
                                end
                                n_ramp = ramp_go;
                                if (r_speed == '0) begin
                                    n_speed = r_start;
                                    n_state = stramp_pkg::ST_FINISH;
                                end else begin
                                    n_state = stramp_pkg::ST_TMUL;
                                end
                            end
                        end
                        stramp_pkg::KIND_MOVE: begin
                            if (cfg_ok) begin
                                n_travel = i_s_tdata - 24'd1;
                                n_state  = stramp_pkg::ST_MMUL;
                            end else begin
                                n_mode   = stramp_pkg::MODE_STANDBY;
                                n_speed  = '0;
                                n_wt     = '0;
                                n_period = '0;
                                n_res    = '0;
                            end
                        end
                        stramp_pkg::KIND_RUN: begin
                            if (cfg_ok) begin
                                n_wt   = r_target;
                                n_ramp = stramp_pkg::RAMP_ACCEL;
                                n_mode = stramp_pkg::MODE_RUN;
                            end else begin
                                n_mode   = stramp_pkg::MODE_STANDBY;
                                n_speed  = '0;
                                n_wt     = '0;
                                n_period = '0;
                                n_res    = '0;
                            end
                        end
                        stramp_pkg::KIND_STOP: begin
                            if (cfg_ok) begin
                                n_ramp = stramp_pkg::RAMP_DECEL;
                                n_wt   = r_start;
                            end
                        end
                    endcase
                end
            end
            stramp_pkg::ST_TMUL: begin
                n_prod  = mul_p;
                n_state = stramp_pkg::ST_TSQ;
            end
            stramp_pkg::ST_TSQ: begin
                n_sroot   = '0;
                n_srem    = '0;
                n_scnt    = '0;
                n_is_move = 1'b0;
                n_state   = stramp_pkg::ST_SQRT;
                if (r_ramp == stramp_pkg::RAMP_ACCEL) begin
                    n_sx = {15'd0, v2_plus};
                end else if (r_prod > {7'd0, k_acc}) begin
                    n_sx = {16'd0, r_prod - {7'd0, k_acc}};
                end else begin
                    n_sroot = {8'd0, r_start};
                    n_state = stramp_pkg::ST_TUPD;
                end
            end
            stramp_pkg::ST_SQRT: begin
                n_srem  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
                n_sroot = {r_sroot[30:0], sq_ge};
                n_sx    = {r_sx[61:0], 2'b00};
                n_scnt  = r_scnt + 5'd1;
                if (r_scnt == 5'd31) begin
                    n_state = r_is_move ? stramp_pkg::ST_MSET : stramp_pkg::ST_TUPD;
                end
            end
            stramp_pkg::ST_TUPD: begin
                n_state = stramp_pkg::ST_FINISH;
                if (r_ramp == stramp_pkg::RAMP_ACCEL) begin
                    if (r_sroot >= {8'd0, r_wt}) begin
                        n_ramp  = stramp_pkg::RAMP_CRUISE;
                        n_speed = r_wt;
                    end else begin
                        n_speed = r_sroot[23:0];
                    end
                end else if (r_sroot <= {8'd0, r_wt}) begin
                    n_speed = r_wt;
                    n_ramp  = stramp_pkg::RAMP_CRUISE;
                    if (r_wt == r_start) begin
                        n_mode   = stramp_pkg::MODE_STANDBY;
                        n_speed  = '0;
                        n_wt     = '0;
                        n_period = '0;
                        n_res    = '0;
                        n_state  = stramp_pkg::ST_EMIT;
                    end
                end else begin
                    n_speed = r_sroot[23:0];
                end
            end
            stramp_pkg::ST_FINISH: begin
                if (r_mode == stramp_pkg::MODE_COUNTED && r_steps != '0) begin
                    n_steps = r_steps - 24'd1;
                end
                if (r_speed == '0) begin
                    n_period = '1;
                    n_res    = '1;
                    n_state  = stramp_pkg::ST_EMIT;
                end else begin
                    n_dnum    = {13'd0, r_tfreq, 8'd0};
                    n_dden    = {16'd0, r_speed};
                    n_drem    = '0;
                    n_dcnt    = '0;
                    n_is_move = 1'b0;
                    n_state   = stramp_pkg::ST_DIV;
                end
            end
            stramp_pkg::ST_DIV: begin
                n_drem = div_ge ? (div_sh - {1'b0, r_dden}) : div_sh;
                n_dnum = {r_dnum[46:0], div_ge};
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd47) begin
                    n_state = r_is_move ? stramp_pkg::ST_MCMP : stramp_pkg::ST_PER;
                end
            end
            stramp_pkg::ST_PER: begin
                n_period = (r_dnum[47:32] != '0) ? '1 : r_dnum[31:0];
                n_res    = (r_dnum[47:32] != '0) ? '1 : r_dnum[31:0];
                n_state  = stramp_pkg::ST_EMIT;
            end
            stramp_pkg::ST_MMUL: begin
                n_dnum    = mul_p;
                n_dden    = {r_accel, 16'd0};
                n_drem    = '0;
                n_dcnt    = '0;
                n_is_move = 1'b1;
                n_state   = stramp_pkg::ST_DIV;
            end
            stramp_pkg::ST_MCMP: begin
                if (q_long) begin
                    n_rdist = {9'd0, half};
                    n_prod  = mul_p;
                    n_state = stramp_pkg::ST_MSQ;
                end else begin
                    n_rdist = r_dnum[32:1];
                    n_wt    = r_target;
                    n_steps = r_travel;
                    n_mode  = stramp_pkg::MODE_COUNTED;
                    n_ramp  = stramp_pkg::RAMP_ACCEL;
                    n_res   = r_period;
                    n_state = stramp_pkg::ST_EMIT;
                end
            end
            stramp_pkg::ST_MSQ: begin
                n_sx      = {r_prod, 16'd0};
                n_sroot   = '0;
                n_srem    = '0;
                n_scnt    = '0;
                n_is_move = 1'b1;
                n_state   = stramp_pkg::ST_SQRT;
            end
            stramp_pkg::ST_MSET: begin
                n_wt    = r_sroot[23:0];
                n_steps = r_travel;
                n_mode  = stramp_pkg::MODE_COUNTED;
                n_ramp  = stramp_pkg::RAMP_ACCEL;
                n_res   = r_period;
                n_state = stramp_pkg::ST_EMIT;
            end
            stramp_pkg::ST_EMIT: begin
                if (emit_load) begin
                    n_state = stramp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stramp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stramp_pkg::ST_IDLE;
            r_mode   <= stramp_pkg::MODE_STANDBY;
            r_ramp   <= stramp_pkg::RAMP_ACCEL;
            r_speed  <= '0;
            r_wt     <= '0;
            r_rdist  <= '0;
            r_steps  <= '0;
            r_period <= '0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_ramp   <= n_ramp;
            r_speed  <= n_speed;
            r_wt     <= n_wt;
            r_rdist  <= n_rdist;
            r_steps  <= n_steps;
            r_period <= n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        r_travel  <= n_travel;
        r_res     <= n_res;
        r_prod    <= n_prod;
        r_dnum    <= n_dnum;
        r_drem    <= n_drem;
        r_dden    <= n_dden;
        r_dcnt    <= n_dcnt;
        r_sx      <= n_sx;
        r_sroot   <= n_sroot;
        r_srem    <= n_srem;
        r_scnt    <= n_scnt;
        r_is_move <= n_is_move;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_accel  <= '0;
            r_start  <= 24'd256;
            r_tfreq  <= 27'd72000000;
        end else if (i_cfg_we) begin
            unique case (stramp_pkg::t_cfg_idx'(i_cfg_addr))
                stramp_pkg::CFG_TARGET: r_target <= i_cfg_data[23:0];
                stramp_pkg::CFG_ACCEL:  r_accel  <= i_cfg_data[23:0];
                stramp_pkg::CFG_START:  r_start  <= i_cfg_data[23:0];
                stramp_pkg::CFG_TFREQ:  r_tfreq  <= i_cfg_data;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_period <= r_res;
            r_out_mode   <= r_mode;
            r_out_ramp   <= r_ramp;
        end
    end

    `STRAMP_ASSERT_IMPL(a_standby_stopped, i_clk, i_rst_n,
        r_state == stramp_pkg::ST_IDLE && r_mode == stramp_pkg::MODE_STANDBY,
        r_period == '0)
    `STRAMP_ASSERT_NEXT(a_cmd_leaves_idle, i_clk, i_rst_n,
        r_state == stramp_pkg::ST_IDLE && i_s_tvalid, r_state != stramp_pkg::ST_IDLE)
    `STRAMP_ASSERT_NEXT(a_sqrt_runs_full, i_clk, i_rst_n,
        r_state == stramp_pkg::ST_SQRT && r_scnt != 5'd31, r_state == stramp_pkg::ST_SQRT)

endmodule
